>>> hw/rtl/pbf_pkg.sv
// shared types, constants and helpers for the packet block fifo
`default_nettype none

package pbf_pkg;

  localparam int MAX_BLOCKS_DEF  = 16;
  localparam int BLOCK_BYTES_DEF = 64;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam int ACT_W      = 5;
  localparam int LEN_W      = 7;
  localparam int BYTE_W     = 8;

  localparam logic [ACT_W-1:0] ACTIVE_RESET = 5'd16;
  localparam logic [LEN_W-1:0] BYTES_RESET  = 7'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE_BLOCKS = 1'b0,
    REG_BLOCK_BYTES   = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_READ  = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    KIND_STORED  = 2'd0,
    KIND_DROPPED = 2'd1,
    KIND_BYTE    = 2'd2,
    KIND_EMPTY   = 2'd3
  } kind_t;

  typedef enum logic {
    CMD_RESULT = 1'b0,
    CMD_READ   = 1'b1
  } cmd_op_t;

  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_CALC = 2'd1,
    B_DATA = 2'd2
  } bk_state_t;

  typedef struct packed {
    func_t             func;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
    logic [LEN_W-1:0]  read_limit;
  } pbf_in_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] out_byte;
    logic [LEN_W-1:0]  count;
    logic              last_out;
  } pbf_out_t;

  // value is the count for a result, the limit for a read
  typedef struct packed {
    cmd_op_t          op;
    kind_t            kind;
    logic [LEN_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic rd_done;
  } bk_status_t;

  function automatic int idx_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/pbf_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none

module pbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                clk,
  input  wire logic                                we,
  input  wire logic [pbf_pkg::idx_w(DEPTH)-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0]                    wr_data,
  input  wire logic                                re,
  input  wire logic [pbf_pkg::idx_w(DEPTH)-1:0]    rd_addr,
  output      logic [WIDTH-1:0]                    rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> hw/rtl/pbf_queue.sv
// short command queue between the front and back parts
`default_nettype none

module pbf_queue #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output      logic             push_ready,
  input  wire logic             pop,
  output      logic [WIDTH-1:0] pop_data,
  output      logic             pop_valid
);

  localparam int PW = pbf_pkg::idx_w(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign push_ready = (cnt_r != CW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = entries_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (int'(wr_ptr_r) == DEPTH - 1) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (int'(rd_ptr_r) == DEPTH - 1) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/pbf_front.sv
// front part: config registers, write side state, ring bookkeeping, command issue
`default_nettype none

module pbf_front #(
  parameter int MAX_BLOCKS  = pbf_pkg::MAX_BLOCKS_DEF,
  parameter int BLOCK_BYTES = pbf_pkg::BLOCK_BYTES_DEF,
  parameter int QUEUE_DEPTH = pbf_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst_n,
  input  wire logic                                          in_valid,
  output      logic                                          in_ready,
  input  wire pbf_pkg::pbf_in_t                              in_data,
  input  wire logic                                          cfg_we,
  input  wire logic [pbf_pkg::CFG_IDX_W-1:0]                 cfg_idx,
  input  wire logic [pbf_pkg::CFG_DATA_W-1:0]                cfg_data,
  output      logic                                          q_push,
  output      pbf_pkg::cmd_t                                 q_cmd,
  output      logic [pbf_pkg::idx_w(MAX_BLOCKS)-1:0]         q_head,
  input  wire logic                                          q_ready,
  input  wire pbf_pkg::bk_status_t                           bk_status,
  output      logic                                          dat_we,
  output      logic [pbf_pkg::idx_w(MAX_BLOCKS*BLOCK_BYTES)-1:0] dat_addr,
  output      logic [pbf_pkg::BYTE_W-1:0]                    dat_wdata,
  output      logic                                          len_we,
  output      logic [pbf_pkg::idx_w(MAX_BLOCKS)-1:0]         len_addr,
  output      logic [pbf_pkg::LEN_W-1:0]                     len_wdata
);

  localparam int IDX_W  = pbf_pkg::idx_w(MAX_BLOCKS);
  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int ADDR_W = pbf_pkg::idx_w(MAX_BLOCKS * BLOCK_BYTES);
  localparam int RC_W   = $clog2(QUEUE_DEPTH + 2);
  localparam int LEN_W  = pbf_pkg::LEN_W;

  logic [pbf_pkg::ACT_W-1:0] act_r, act_nxt;
  logic [LEN_W-1:0]          bytes_r, bytes_nxt;
  logic [IDX_W-1:0]          head_r, head_nxt;
  logic [IDX_W-1:0]          tail_r, tail_nxt;
  logic [CNT_W-1:0]          used_r, used_nxt;
  logic [LEN_W-1:0]          fill_r, fill_nxt;
  logic                      drop_r, drop_nxt;
  logic [RC_W-1:0]           rd_cnt_r, rd_cnt_nxt;

  logic [CNT_W-1:0] eff_act;
  logic [LEN_W-1:0] eff_bytes;
  logic             acc, is_wr, drop_now, store, commit, drop_ack, rd_empty, rd_go;
  logic [LEN_W-1:0] fill_after;

  function automatic logic [IDX_W-1:0] step_idx(input logic [IDX_W-1:0] i,
                                                input logic [CNT_W-1:0] lim);
    int n;
    n = int'(i) + 1;
    return (n >= int'(lim)) ? '0 : IDX_W'(n);
  endfunction

  always_comb begin
    if (act_r == '0) begin
      eff_act = CNT_W'(1);
    end else if (int'(act_r) > MAX_BLOCKS) begin
      eff_act = CNT_W'(MAX_BLOCKS);
    end else begin
      eff_act = CNT_W'(act_r);
    end
    if (bytes_r == '0) begin
      eff_bytes = LEN_W'(1);
    end else if (int'(bytes_r) > BLOCK_BYTES) begin
      eff_bytes = LEN_W'(BLOCK_BYTES);
    end else begin
      eff_bytes = bytes_r;
    end
  end

  assign in_ready = q_ready && ((in_data.func != pbf_pkg::FUNC_WRITE) || (rd_cnt_r == '0));
  assign acc      = in_valid && in_ready;

  // item classification
  always_comb begin
    is_wr      = (in_data.func == pbf_pkg::FUNC_WRITE);
    drop_now   = drop_r || ((fill_r == '0) && (used_r >= eff_act));
    store      = is_wr && !drop_now && (fill_r < eff_bytes);
    fill_after = store ? fill_r + LEN_W'(1) : fill_r;
    commit     = is_wr && !drop_now && in_data.last_byte;
    drop_ack   = is_wr && drop_now && in_data.last_byte;
    rd_empty   = !is_wr && ((in_data.read_limit == '0) || (used_r == '0));
    rd_go      = !is_wr && !rd_empty;
  end

  always_comb begin
    q_push = acc && (commit || drop_ack || !is_wr);
    q_head = head_r;
    q_cmd.op    = rd_go ? pbf_pkg::CMD_READ : pbf_pkg::CMD_RESULT;
    q_cmd.kind  = pbf_pkg::KIND_EMPTY;
    q_cmd.value = '0;
    if (commit) begin
      q_cmd.kind  = pbf_pkg::KIND_STORED;
      q_cmd.value = fill_after;
    end else if (drop_ack) begin
      q_cmd.kind = pbf_pkg::KIND_DROPPED;
    end else if (rd_go) begin
      q_cmd.value = in_data.read_limit;
    end
  end

  assign dat_we    = acc && store;
  assign dat_addr  = ADDR_W'(int'(tail_r) * BLOCK_BYTES + int'(fill_r));
  assign dat_wdata = in_data.data_byte;
  assign len_we    = acc && commit;
  assign len_addr  = tail_r;
  assign len_wdata = fill_after;

  always_comb begin
    act_nxt    = act_r;
    bytes_nxt  = bytes_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    used_nxt   = used_r;
    fill_nxt   = fill_r;
    drop_nxt   = drop_r;
    rd_cnt_nxt = rd_cnt_r;
    if (cfg_we) begin
      case (pbf_pkg::cfg_reg_t'(cfg_idx))
        pbf_pkg::REG_ACTIVE_BLOCKS: act_nxt = cfg_data[pbf_pkg::ACT_W-1:0];
        pbf_pkg::REG_BLOCK_BYTES:   bytes_nxt = cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
    if (acc && is_wr) begin
      if (drop_now) begin
        drop_nxt = !in_data.last_byte;
      end else if (commit) begin
        fill_nxt = '0;
        tail_nxt = step_idx(tail_r, eff_act);
        used_nxt = used_r + CNT_W'(1);
      end else begin
        fill_nxt = fill_after;
      end
    end
    if (acc && rd_go) begin
      head_nxt = step_idx(head_r, eff_act);
      used_nxt = used_r - CNT_W'(1);
    end
    if ((acc && rd_go) && !bk_status.rd_done) begin
      rd_cnt_nxt = rd_cnt_r + RC_W'(1);
    end else if (!(acc && rd_go) && bk_status.rd_done) begin
      rd_cnt_nxt = rd_cnt_r - RC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r    <= pbf_pkg::ACTIVE_RESET;
      bytes_r  <= pbf_pkg::BYTES_RESET;
      head_r   <= '0;
      tail_r   <= '0;
      used_r   <= '0;
      fill_r   <= '0;
      drop_r   <= 1'b0;
      rd_cnt_r <= '0;
    end else begin
      act_r    <= act_nxt;
      bytes_r  <= bytes_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      used_r   <= used_nxt;
      fill_r   <= fill_nxt;
      drop_r   <= drop_nxt;
      rd_cnt_r <= rd_cnt_nxt;
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(used_r) <= MAX_BLOCKS)
    else $error("used block count above ring size");

  a_rd_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(rd_cnt_r) <= QUEUE_DEPTH + 1)
    else $error("outstanding read count above queue capacity");

  a_drop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    drop_r |-> (fill_r == '0))
    else $error("bytes stored while dropping a packet");

endmodule

`default_nettype wire

>>> hw/rtl/pbf_back.sv
// back part: executes queued commands and drives the result register
`default_nettype none

module pbf_back #(
  parameter int MAX_BLOCKS  = pbf_pkg::MAX_BLOCKS_DEF,
  parameter int BLOCK_BYTES = pbf_pkg::BLOCK_BYTES_DEF
) (
  input  wire logic                                              clk,
  input  wire logic                                              rst_n,
  input  wire logic                                              q_valid,
  input  wire pbf_pkg::cmd_t                                     q_cmd,
  input  wire logic [pbf_pkg::idx_w(MAX_BLOCKS)-1:0]             q_head,
  output      logic                                              q_pop,
  output      logic                                              len_re,
  output      logic [pbf_pkg::idx_w(MAX_BLOCKS)-1:0]             len_addr,
  input  wire logic [pbf_pkg::LEN_W-1:0]                         len_rdata,
  output      logic                                              dat_re,
  output      logic [pbf_pkg::idx_w(MAX_BLOCKS*BLOCK_BYTES)-1:0] dat_addr,
  input  wire logic [pbf_pkg::BYTE_W-1:0]                        dat_rdata,
  output      logic                                              out_valid,
  input  wire logic                                              out_ready,
  output      pbf_pkg::pbf_out_t                                 out_data,
  output      pbf_pkg::bk_status_t                               bk_status
);

  localparam int ADDR_W = pbf_pkg::idx_w(MAX_BLOCKS * BLOCK_BYTES);
  localparam int LEN_W  = pbf_pkg::LEN_W;

  pbf_pkg::bk_state_t state_r, state_nxt;
  logic [ADDR_W-1:0]  base_r, base_nxt;
  logic [LEN_W-1:0]   lim_r, lim_nxt;
  logic [LEN_W-1:0]   n_r, n_nxt;
  logic [LEN_W-1:0]   k_r, k_nxt;
  logic               out_valid_r, out_valid_nxt;
  pbf_pkg::pbf_out_t  out_data_r;

  logic              out_free, load, is_last;
  logic [LEN_W-1:0]  len_clip, calc_n;
  pbf_pkg::pbf_out_t res;

  assign out_free = !out_valid_r || out_ready;
  assign is_last  = ((k_r + LEN_W'(1)) == n_r);

  always_comb begin
    len_clip = (int'(len_rdata) > BLOCK_BYTES) ? LEN_W'(BLOCK_BYTES) : len_rdata;
    calc_n   = (lim_r < len_clip) ? lim_r : len_clip;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pbf_pkg::B_IDLE: begin
        if (q_valid && (q_cmd.op == pbf_pkg::CMD_READ)) begin
          state_nxt = pbf_pkg::B_CALC;
        end
      end
      pbf_pkg::B_CALC: begin
        if (calc_n != '0) begin
          state_nxt = pbf_pkg::B_DATA;
        end else if (out_free) begin
          state_nxt = pbf_pkg::B_IDLE;
        end
      end
      pbf_pkg::B_DATA: begin
        if (out_free && is_last) begin
          state_nxt = pbf_pkg::B_IDLE;
        end
      end
      default: state_nxt = pbf_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    q_pop             = 1'b0;
    len_re            = 1'b0;
    len_addr          = q_head;
    dat_re            = 1'b0;
    dat_addr          = ADDR_W'(int'(q_head) * BLOCK_BYTES);
    base_nxt          = base_r;
    lim_nxt           = lim_r;
    n_nxt             = n_r;
    k_nxt             = k_r;
    load              = 1'b0;
    bk_status.rd_done = 1'b0;
    res.kind          = pbf_pkg::KIND_EMPTY;
    res.out_byte      = '0;
    res.count         = '0;
    res.last_out      = 1'b1;
    case (state_r)
      pbf_pkg::B_IDLE: begin
        if (q_valid && (q_cmd.op == pbf_pkg::CMD_READ)) begin
          q_pop    = 1'b1;
          len_re   = 1'b1;
          dat_re   = 1'b1;
          base_nxt = ADDR_W'(int'(q_head) * BLOCK_BYTES);
          lim_nxt  = q_cmd.value;
        end else if (q_valid && out_free) begin
          q_pop     = 1'b1;
          load      = 1'b1;
          res.kind  = q_cmd.kind;
          res.count = q_cmd.value;
        end
      end
      pbf_pkg::B_CALC: begin
        n_nxt = calc_n;
        k_nxt = '0;
        if ((calc_n == '0) && out_free) begin
          load              = 1'b1;
          bk_status.rd_done = 1'b1;
        end
      end
      pbf_pkg::B_DATA: begin
        if (out_free) begin
          load         = 1'b1;
          res.kind     = pbf_pkg::KIND_BYTE;
          res.out_byte = dat_rdata;
          res.count    = n_r;
          res.last_out = is_last;
          if (is_last) begin
            bk_status.rd_done = 1'b1;
          end else begin
            k_nxt    = k_r + LEN_W'(1);
            dat_re   = 1'b1;
            dat_addr = base_r + ADDR_W'(k_r) + ADDR_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pbf_pkg::B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    lim_r  <= lim_nxt;
    n_r    <= n_nxt;
    k_r    <= k_nxt;
    if (load) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_data_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pbf_pkg::B_DATA) |-> ((n_r != '0) && (k_r < n_r)))
    else $error("byte index outside packet length");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    bk_status.rd_done |-> (load && res.last_out))
    else $error("read finished without a closing result");

  a_calc_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pbf_pkg::B_CALC) && ($past(state_r) == pbf_pkg::B_IDLE) |-> $past(q_pop))
    else $error("read started without a queued command");

endmodule

`default_nettype wire

>>> hw/rtl/packet_block_fifo_core.sv
// top level of the packet block fifo
//
// in_*  : item channel, valid/ready. func write carries one byte of a packet,
//         last_byte closes it; func read asks for the packet at the head block.
// out_* : result channel, valid/ready, one beat per result. A closed packet
//         gives one ack beat (stored or dropped); a read gives one beat per
//         byte delivered, the last one marked, or a single empty beat.
// cfg_* : register writes (active block count, block size), taken at once.
// Write bytes are taken one per cycle while in_ready is high. A closing byte's
// ack passes the command queue and the result register. A read passes the queue
// and the ram reads, then gives one byte per cycle while out_ready stays high.
// Write items are held off while an accepted read is queued or being delivered.
// The command queue between the front and back parts holds a few commands,
// so items keep flowing while the result register waits on out_ready; when
// the queue fills, in_ready drops. A stalled result beat holds its value.
// Synchronous active-low reset empties the ring, the queue and the result
// register and restores the register defaults; stored bytes are kept.
`default_nettype none

module packet_block_fifo_core #(
  parameter int MAX_BLOCKS  = pbf_pkg::MAX_BLOCKS_DEF,
  parameter int BLOCK_BYTES = pbf_pkg::BLOCK_BYTES_DEF,
  parameter int QUEUE_DEPTH = pbf_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output      logic                                in_ready,
  input  wire pbf_pkg::pbf_in_t                    in_data,
  output      logic                                out_valid,
  input  wire logic                                out_ready,
  output      pbf_pkg::pbf_out_t                   out_data,
  input  wire logic                                cfg_we,
  input  wire logic [pbf_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  wire logic [pbf_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int IDX_W  = pbf_pkg::idx_w(MAX_BLOCKS);
  localparam int ADDR_W = pbf_pkg::idx_w(MAX_BLOCKS * BLOCK_BYTES);
  localparam int Q_W    = $bits(pbf_pkg::cmd_t) + IDX_W;

  logic                       f_push, q_ready, q_valid, q_pop;
  pbf_pkg::cmd_t              f_cmd, b_cmd;
  logic [IDX_W-1:0]           f_head, b_head;
  logic [Q_W-1:0]             q_in, q_out;
  pbf_pkg::bk_status_t        bk_status;

  logic                       dat_we, dat_re;
  logic [ADDR_W-1:0]          dat_waddr, dat_raddr;
  logic [pbf_pkg::BYTE_W-1:0] dat_wdata, dat_rdata;
  logic                       len_we, len_re;
  logic [IDX_W-1:0]           len_waddr, len_raddr;
  logic [pbf_pkg::LEN_W-1:0]  len_wdata, len_rdata;

  pbf_front #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .BLOCK_BYTES(BLOCK_BYTES),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .q_push   (f_push),
    .q_cmd    (f_cmd),
    .q_head   (f_head),
    .q_ready  (q_ready),
    .bk_status(bk_status),
    .dat_we   (dat_we),
    .dat_addr (dat_waddr),
    .dat_wdata(dat_wdata),
    .len_we   (len_we),
    .len_addr (len_waddr),
    .len_wdata(len_wdata)
  );

  assign q_in = {f_head, f_cmd};

  pbf_queue #(
    .WIDTH(Q_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_data (q_in),
    .push_ready(q_ready),
    .pop       (q_pop),
    .pop_data  (q_out),
    .pop_valid (q_valid)
  );

  assign b_head = q_out[Q_W-1 -: IDX_W];
  assign b_cmd  = pbf_pkg::cmd_t'(q_out[$bits(pbf_pkg::cmd_t)-1:0]);

  pbf_ram #(
    .WIDTH(pbf_pkg::BYTE_W),
    .DEPTH(MAX_BLOCKS * BLOCK_BYTES)
  ) u_data_ram (
    .clk    (clk),
    .we     (dat_we),
    .wr_addr(dat_waddr),
    .wr_data(dat_wdata),
    .re     (dat_re),
    .rd_addr(dat_raddr),
    .rd_data(dat_rdata)
  );

  pbf_ram #(
    .WIDTH(pbf_pkg::LEN_W),
    .DEPTH(MAX_BLOCKS)
  ) u_len_ram (
    .clk    (clk),
    .we     (len_we),
    .wr_addr(len_waddr),
    .wr_data(len_wdata),
    .re     (len_re),
    .rd_addr(len_raddr),
    .rd_data(len_rdata)
  );

  pbf_back #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_cmd    (b_cmd),
    .q_head   (b_head),
    .q_pop    (q_pop),
    .len_re   (len_re),
    .len_addr (len_raddr),
    .len_rdata(len_rdata),
    .dat_re   (dat_re),
    .dat_addr (dat_raddr),
    .dat_rdata(dat_rdata),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .bk_status(bk_status)
  );

endmodule

`default_nettype wire

>>> sim/pbf_checker.sv
// result checker for the packet block fifo: tracks the ring, predicts and compares every beat
module pbf_checker
  import pbf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  pbf_in_t               in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  pbf_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    beats_waiting,
  output int                    blocks_held,
  output int                    beats_checked,
  output int                    fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [BYTE_W-1:0] blk_data [MAX_BLOCKS_DEF][BLOCK_BYTES_DEF];
  int                blk_len  [MAX_BLOCKS_DEF];
  int                head_blk;
  int                tail_blk;
  int                blocks_used;
  int                fill_len;
  bit                dropping;
  logic [ACT_W-1:0]  act_reg;
  logic [LEN_W-1:0]  len_reg;
  pbf_out_t          due_beats [$];
  int                n_fail    = 0;
  int                n_checked = 0;

  initial begin
    beats_waiting = 0;
    blocks_held   = 0;
    beats_checked = 0;
    fail_count    = 0;
  end

  function automatic int ring_size();
    if (act_reg < 1) return 1;
    if (act_reg > MAX_BLOCKS_DEF) return MAX_BLOCKS_DEF;
    return act_reg;
  endfunction

  function automatic int block_cap();
    if (len_reg < 1) return 1;
    if (len_reg > BLOCK_BYTES_DEF) return BLOCK_BYTES_DEF;
    return len_reg;
  endfunction

  function automatic int step_blk(int idx);
    return (idx + 1 >= ring_size()) ? 0 : idx + 1;
  endfunction

  function automatic void add_beat(kind_t k, logic [BYTE_W-1:0] b, int cnt, logic lst);
    pbf_out_t r;
    r.kind     = k;
    r.out_byte = b;
    r.count    = LEN_W'(cnt);
    r.last_out = lst;
    due_beats.push_back(r);
  endfunction

  function automatic void predict_beats(pbf_in_t it);
    int h;
    int len;
    int n;
    if (it.func == FUNC_WRITE) begin
      if (!dropping && fill_len == 0 && blocks_used >= ring_size()) dropping = 1'b1;
      if (dropping) begin
        if (it.last_byte) begin
          dropping = 1'b0;
          add_beat(KIND_DROPPED, '0, 0, 1'b1);
        end
        return;
      end
      if (fill_len < block_cap()) begin
        blk_data[tail_blk][fill_len] = it.data_byte;
        fill_len++;
      end
      if (it.last_byte) begin
        blk_len[tail_blk] = fill_len;
        add_beat(KIND_STORED, '0, fill_len, 1'b1);
        tail_blk = step_blk(tail_blk);
        blocks_used++;
        fill_len = 0;
      end
    end else if (it.read_limit == 0 || blocks_used == 0) begin
      add_beat(KIND_EMPTY, '0, 0, 1'b1);
    end else begin
      h   = head_blk;
      len = blk_len[h];
      if (len > BLOCK_BYTES_DEF) len = BLOCK_BYTES_DEF;
      n = (it.read_limit < len) ? int'(it.read_limit) : len;
      head_blk = step_blk(h);
      blocks_used--;
      if (n == 0) begin
        add_beat(KIND_EMPTY, '0, 0, 1'b1);
      end else begin
        for (int k = 0; k < n; k++) add_beat(KIND_BYTE, blk_data[h][k], n, k + 1 == n);
      end
    end
  endfunction

  function automatic void check_beat(pbf_out_t got);
    pbf_out_t want;
    if (due_beats.size() == 0) begin
      $error("result beat with nothing expected: kind %0d byte %0h count %0d last %0b",
             got.kind, got.out_byte, got.count, got.last_out);
      n_fail++;
      return;
    end
    want = due_beats.pop_front();
    n_checked++;
    if (got.kind !== want.kind) begin
      $error("kind: expected %0d, got %0d", want.kind, got.kind);
      n_fail++;
    end
    if (got.out_byte !== want.out_byte) begin
      $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
      n_fail++;
    end
    if (got.count !== want.count) begin
      $error("count: expected %0d, got %0d", want.count, got.count);
      n_fail++;
    end
    if (got.last_out !== want.last_out) begin
      $error("last_out: expected %0b, got %0b", want.last_out, got.last_out);
      n_fail++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      due_beats.delete();
      head_blk    = 0;
      tail_blk    = 0;
      blocks_used = 0;
      fill_len    = 0;
      dropping    = 1'b0;
      act_reg     = ACTIVE_RESET;
      len_reg     = BYTES_RESET;
    end else begin
      if (out_valid && out_ready) check_beat(out_data);
      if (cfg_we) begin
        if (cfg_reg_t'(cfg_idx) == REG_ACTIVE_BLOCKS) act_reg = cfg_data[ACT_W-1:0];
        else len_reg = cfg_data[LEN_W-1:0];
      end
      if (in_valid && in_ready) predict_beats(in_data);
    end
    beats_waiting <= due_beats.size();
    blocks_held   <= blocks_used;
    beats_checked <= n_checked;
    fail_count    <= n_fail;
  end

endmodule

>>> sim/tb_top.sv
// testbench top for the packet block fifo: clock, reset, stimulus and verdict
module tb_top;
  import pbf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int PHASE_BEATS     = 18;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  pbf_in_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  pbf_out_t              out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int beats_waiting;
  int blocks_held;
  int beats_checked;
  int fail_count;

  int  beats_sent    = 0;
  int  settings_used = 0;
  int  burst_left    = 0;
  bit  no_gaps       = 1'b0;
  int  quiet_cycles  = 0;
  int  stall_mode    = 0;
  int  mode_left     = 0;

  packet_block_fifo_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data)
  );

  pbf_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_data      (cfg_data),
    .beats_waiting (beats_waiting),
    .blocks_held   (blocks_held),
    .beats_checked (beats_checked),
    .fail_count    (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver: always ready, random, or long stalls
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(20, 80);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 9) < 7);
      default: out_ready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic send_beat(pbf_in_t it);
    int gap;
    if (burst_left == 0) begin
      gap        = no_gaps ? 0 : $urandom_range(0, 6);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  task automatic send_write(logic [BYTE_W-1:0] b, logic lst);
    pbf_in_t it;
    it.func       = FUNC_WRITE;
    it.data_byte  = b;
    it.last_byte  = lst;
    it.read_limit = LEN_W'($urandom_range(0, 127));
    send_beat(it);
  endtask

  task automatic send_packet(int len);
    for (int k = 0; k < len; k++) send_write(BYTE_W'($urandom_range(0, 255)), k == len - 1);
  endtask

  task automatic send_read(int lim);
    pbf_in_t it;
    it.func       = FUNC_READ;
    it.data_byte  = BYTE_W'($urandom_range(0, 255));
    it.last_byte  = 1'($urandom_range(0, 1));
    it.read_limit = LEN_W'(lim);
    send_beat(it);
  endtask

  task automatic wait_quiet();
    in_valid   <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (beats_waiting != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic drain_ring();
    wait_quiet();
    while (blocks_held != 0) begin
      repeat (blocks_held) send_read(BLOCK_BYTES_DEF);
      wait_quiet();
    end
  endtask

  task automatic set_regs(logic [CFG_DATA_W-1:0] act, logic [CFG_DATA_W-1:0] len);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_ACTIVE_BLOCKS;
    cfg_data <= act;
    @(posedge clk);
    cfg_idx  <= REG_BLOCK_BYTES;
    cfg_data <= len;
    @(posedge clk);
    cfg_we   <= 1'b0;
    settings_used++;
  endtask

  task automatic random_phase(int quota);
    int first;
    int pick;
    first = beats_sent;
    while (beats_sent - first < quota) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        if ($urandom_range(0, 99) < 85) send_packet($urandom_range(1, 6));
        else send_packet($urandom_range(7, 70));
      end else if (pick < 92) begin
        pick = $urandom_range(0, 99);
        if (pick < 85) send_read($urandom_range(1, 64));
        else if (pick < 90) send_read(0);
        else send_read($urandom_range(65, 127));
      end else begin
        send_write(BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  logic [CFG_DATA_W-1:0] act_plan [7] = '{7'd16, 7'd1, 7'd4, 7'h00, 7'd3, 7'h7F, 7'd2};
  logic [CFG_DATA_W-1:0] len_plan [7] = '{7'd64, 7'd1, 7'd8, 7'd65, 7'd64, 7'd5, 7'd33};

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty ring and zero limit
    send_read(5);
    send_read(0);
    // extreme bytes, then whole and partial reads
    send_write(8'h00, 1'b1);
    send_write(8'hFF, 1'b0);
    send_write(8'hA5, 1'b1);
    send_read(127);
    send_read(1);

    // one block of one byte: truncation and full-ring drop
    drain_ring();
    set_regs(7'h00, 7'h00);
    send_packet(3);
    send_packet(2);
    send_read(64);

    // block size shrunk under an open packet
    drain_ring();
    set_regs(7'h7F, 7'h7F);
    for (int k = 0; k < 4; k++) send_write(BYTE_W'($urandom_range(0, 255)), 1'b0);
    wait_quiet();
    set_regs(7'd16, 7'd2);
    send_write(BYTE_W'($urandom_range(0, 255)), 1'b1);
    send_read(64);

    for (int p = 0; p < 7; p++) begin
      drain_ring();
      set_regs(act_plan[p], len_plan[p]);
      no_gaps = p[0];
      random_phase(PHASE_BEATS);
    end

    wait_quiet();
    $display("%0d input beats over %0d register settings, %0d result beats compared",
             beats_sent, settings_used, beats_checked);
    $display("covered empty and zero-limit reads, full-ring drops, truncation and resizing");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/pbf_pkg.sv
hw/rtl/pbf_ram.sv
hw/rtl/pbf_queue.sv
hw/rtl/pbf_front.sv
hw/rtl/pbf_back.sv
hw/rtl/packet_block_fifo_core.sv
sim/pbf_checker.sv
sim/tb_top.sv
